// ----- sv/rcnh_pkg.sv -----
// Shared types, constants and saturating arithmetic helpers for the ray-cone nearest-hit block.
`default_nettype none
package rcnh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int WIDE_WIDTH  = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] MIN_DIST_RESET = 32'd66;

    typedef logic signed [WIDE_WIDTH-1:0] wide_t;

    localparam wide_t SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint TOL_RAW   = ((64'sd1 <<< FRAC_BITS) + 50000) / 100000;
    localparam wide_t  DELTA_TOL = (TOL_RAW == 0) ? 64'sd1 : wide_t'(TOL_RAW);
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = '1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
        logic [COORD_WIDTH-1:0]        tan_sq;
        logic [INDEX_WIDTH-1:0]        cone_index;
        logic                          first_of_ray;
        logic                          last_of_ray;
    } in_item_t;

    typedef struct packed {
        logic                          hit;
        logic [COORD_WIDTH-1:0]        distance;
        logic [INDEX_WIDTH-1:0]        hit_cone;
        logic signed [COORD_WIDTH-1:0] hit_pos_x;
        logic signed [COORD_WIDTH-1:0] hit_pos_y;
        logic signed [COORD_WIDTH-1:0] hit_pos_z;
        logic signed [COORD_WIDTH-1:0] hit_dir_x;
        logic signed [COORD_WIDTH-1:0] hit_dir_y;
        logic signed [COORD_WIDTH-1:0] hit_dir_z;
    } out_item_t;

    // Front-to-back queue status
    typedef struct packed {
        logic     empty;
        in_item_t head;
    } queue_stat_t;

    function automatic wide_t sadd(wide_t x, wide_t y);
        logic signed [WIDE_WIDTH:0] s;
        s = (WIDE_WIDTH+1)'(x) + (WIDE_WIDTH+1)'(y);
        if (s > (WIDE_WIDTH+1)'(SMAX))
            return SMAX;
        else if (s < -(WIDE_WIDTH+1)'(SMAX))
            return -SMAX;
        else
            return wide_t'(s[WIDE_WIDTH-1:0]);
    endfunction

    function automatic wide_t ssub(wide_t x, wide_t y);
        logic signed [WIDE_WIDTH:0] s;
        s = (WIDE_WIDTH+1)'(x) - (WIDE_WIDTH+1)'(y);
        if (s > (WIDE_WIDTH+1)'(SMAX))
            return SMAX;
        else if (s < -(WIDE_WIDTH+1)'(SMAX))
            return -SMAX;
        else
            return wide_t'(s[WIDE_WIDTH-1:0]);
    endfunction

    function automatic wide_t dbl(wide_t x);
        return sadd(x, x);
    endfunction

    function automatic logic [WIDE_WIDTH-2:0] mag(wide_t x);
        wide_t n;
        n = (x < 0) ? -x : x;
        return n[WIDE_WIDTH-2:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/rcnh_front.sv -----
// Input queue: accepts items and holds them until the back end takes them.
`default_nettype none
module rcnh_front
    import rcnh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    item,
    input  wire logic        take,
    output queue_stat_t      stat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_item_t          mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic              do_push, do_take;

    assign full       = (count_reg == (PW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.head  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_take    = take && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_take)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PW+1)'(do_push) - (PW+1)'(do_take);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/rcnh_back.sv -----
// Intersection engine: shared multiplier, square root and divider sequencer, nearest record.
`default_nettype none
module rcnh_back
    import rcnh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire queue_stat_t       stat,
    output logic                   take,
    input  wire logic [31:0]       min_dist,
    output logic                   empty,
    input  wire logic              pop,
    output out_item_t              result
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MFIN  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DLOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DFIN  = 4'd8;
    localparam logic [3:0] S_PICK  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    localparam logic [3:0] LAST_STEP = 4'd13;
    localparam int DIV_BITS = WIDE_WIDTH - 1 + FRAC_BITS;
    localparam int SQ_BITS  = (DIV_BITS + 2) / 2;
    localparam int SQ_OP    = 2 * SQ_BITS;
    localparam int SQ_REM   = SQ_BITS + 4;

    logic [3:0]   state_reg, state_next;
    logic [3:0]   step_reg, step_next;
    in_item_t     item_reg, item_next;

    wide_t        a_reg, a_next, b_reg, b_next, c_reg, c_next;
    wide_t        t_reg, t_next, u_reg, u_next, s_reg, s_next;
    wide_t        x1_reg, x1_next, x2_reg, x2_next;
    logic         single_reg, single_next, valid_reg, valid_next;
    logic         phase_reg, phase_next;

    logic [WIDE_WIDTH-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic                    mneg_reg, mneg_next;
    logic [2*WIDE_WIDTH-1:0] macc_reg, macc_next;
    logic [1:0]              mcnt_reg, mcnt_next;

    logic [SQ_OP-1:0]        sq_op_reg, sq_op_next;
    logic [SQ_REM-1:0]       sq_rem_reg, sq_rem_next;
    logic [SQ_BITS-1:0]      sq_root_reg, sq_root_next;

    logic [DIV_BITS-1:0]     dv_reg, dv_next;
    logic [WIDE_WIDTH-1:0]   rem_reg, rem_next, q_reg, q_next, ud_reg, ud_next;
    logic                    qovf_reg, qovf_next, dneg_reg, dneg_next;
    logic [6:0]              cnt_reg, cnt_next;

    logic                    found_reg, found_next;
    logic [COORD_WIDTH-1:0]  ndist_reg, ndist_next;
    logic [INDEX_WIDTH-1:0]  ncone_reg, ncone_next;
    in_item_t                nray_reg, nray_next;

    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    wide_t                   op_x, op_y, prod, negb, num, tsel, qsat;
    logic [31:0]             xs, ys;
    logic [63:0]             pp;
    logic [2*WIDE_WIDTH-1:0] pp_sh;
    logic [SQ_REM-1:0]       sq_cat, sq_trial;
    logic [WIDE_WIDTH:0]     r65;
    logic [COORD_WIDTH-1:0]  dclamp;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign take   = (state_reg == S_IDLE) && !stat.empty;
    assign negb   = -b_reg;

    // Operand pair for each multiply step
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin op_x = wide_t'(item_reg.dir_x); op_y = wide_t'(item_reg.dir_x); end
            4'd1:    begin op_x = wide_t'(item_reg.dir_z); op_y = wide_t'(item_reg.dir_z); end
            4'd2:    begin op_x = wide_t'(item_reg.dir_y); op_y = wide_t'(item_reg.dir_y); end
            4'd4:    begin op_x = wide_t'(item_reg.dir_x); op_y = wide_t'(item_reg.pos_x); end
            4'd5:    begin op_x = wide_t'(item_reg.dir_z); op_y = wide_t'(item_reg.pos_z); end
            4'd6:    begin op_x = wide_t'(item_reg.dir_y); op_y = wide_t'(item_reg.pos_y); end
            4'd8:    begin op_x = wide_t'(item_reg.pos_x); op_y = wide_t'(item_reg.pos_x); end
            4'd9:    begin op_x = wide_t'(item_reg.pos_z); op_y = wide_t'(item_reg.pos_z); end
            4'd10:   begin op_x = wide_t'(item_reg.pos_y); op_y = wide_t'(item_reg.pos_y); end
            4'd3, 4'd7, 4'd11:
                     begin op_x = u_reg; op_y = wide_t'({32'b0, item_reg.tan_sq}); end
            4'd12:   begin op_x = a_reg; op_y = c_reg; end
            default: begin op_x = b_reg; op_y = b_reg; end
        endcase
    end

    // One 32x32 partial product per cycle
    always_comb
    begin
        xs = mcnt_reg[1] ? mx_reg[63:32] : mx_reg[31:0];
        ys = mcnt_reg[0] ? my_reg[63:32] : my_reg[31:0];
        pp = 64'(xs) * 64'(ys);
        unique case ({1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
    end

    always_comb
    begin
        wide_t r;
        r = (|macc_reg[2*WIDE_WIDTH-1:FRAC_BITS+WIDE_WIDTH] || macc_reg[FRAC_BITS+WIDE_WIDTH-1])
            ? SMAX : wide_t'(macc_reg[FRAC_BITS+WIDE_WIDTH-1:FRAC_BITS]);
        prod = mneg_reg ? -r : r;
    end

    always_comb
    begin
        wide_t qq;
        sq_cat   = {sq_rem_reg[SQ_REM-3:0], sq_op_reg[SQ_OP-1:SQ_OP-2]};
        sq_trial = {2'b0, sq_root_reg, 2'b01};
        r65      = {rem_reg, dv_reg[DIV_BITS-1]};
        qq       = (qovf_reg || q_reg[WIDE_WIDTH-1]) ? SMAX : wide_t'(q_reg);
        qsat     = dneg_reg ? -qq : qq;
        if (single_reg)
            num = negb;
        else if (!phase_reg)
            num = ssub(negb, s_reg);
        else
            num = sadd(negb, s_reg);
        tsel   = (!single_reg && (x1_reg < x2_reg) && (x1_reg > 0)) ? x1_reg : x2_reg;
        dclamp = (tsel > wide_t'({32'b0, COORD_MAX})) ? COORD_MAX : tsel[COORD_WIDTH-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg;
        t_next = t_reg; u_next = u_reg; s_next = s_reg;
        x1_next = x1_reg; x2_next = x2_reg;
        single_next = single_reg; valid_next = valid_reg; phase_next = phase_reg;
        mx_next = mx_reg; my_next = my_reg; mneg_next = mneg_reg;
        macc_next = macc_reg; mcnt_next = mcnt_reg;
        sq_op_next = sq_op_reg; sq_rem_next = sq_rem_reg; sq_root_next = sq_root_reg;
        dv_next = dv_reg; rem_next = rem_reg; q_next = q_reg; ud_next = ud_reg;
        qovf_next = qovf_reg; dneg_next = dneg_reg; cnt_next = cnt_reg;
        found_next = found_reg; ndist_next = ndist_reg; ncone_next = ncone_reg;
        nray_next = nray_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !pop;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!stat.empty)
                begin
                    item_next = stat.head;
                    step_next = '0;
                    if (stat.head.first_of_ray)
                    begin
                        found_next = 1'b0;
                        ndist_next = '0;
                        ncone_next = '0;
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                mx_next   = {1'b0, mag(op_x)};
                my_next   = {1'b0, mag(op_y)};
                mneg_next = (op_x < 0) != (op_y < 0);
                macc_next = '0;
                mcnt_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                macc_next = macc_reg + pp_sh;
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd3)
                    state_next = S_MFIN;
            end
            S_MFIN:
            begin
                unique case (step_reg)
                    4'd0, 4'd4, 4'd8:  t_next = prod;
                    4'd1, 4'd5, 4'd9:  t_next = sadd(t_reg, prod);
                    4'd2, 4'd6, 4'd10: u_next = prod;
                    4'd3:              a_next = ssub(t_reg, prod);
                    4'd7:              b_next = dbl(ssub(t_reg, prod));
                    4'd11:             c_next = ssub(t_reg, prod);
                    4'd12:             u_next = dbl(dbl(prod));
                    default:           t_next = ssub(prod, u_reg);
                endcase
                step_next  = step_reg + 1'b1;
                state_next = (step_reg == LAST_STEP) ? S_DEC : S_LOAD;
            end
            S_DEC:
            begin
                // t holds the discriminant, c is free to hold 2a
                c_next     = dbl(a_reg);
                phase_next = 1'b0;
                if (a_reg != 0 && t_reg > -DELTA_TOL)
                begin
                    valid_next = 1'b1;
                    if (t_reg < DELTA_TOL)
                    begin
                        single_next = 1'b1;
                        state_next  = S_DLOAD;
                    end
                    else
                    begin
                        single_next  = 1'b0;
                        sq_op_next   = SQ_OP'({t_reg, FRAC_BITS'(0)});
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        cnt_next     = 7'(SQ_BITS);
                        state_next   = S_SQRT;
                    end
                end
                else
                begin
                    valid_next = 1'b0;
                    state_next = S_PICK;
                end
            end
            S_SQRT:
            begin
                sq_op_next = {sq_op_reg[SQ_OP-3:0], 2'b00};
                if (sq_cat >= sq_trial)
                begin
                    sq_rem_next  = sq_cat - sq_trial;
                    sq_root_next = {sq_root_reg[SQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_next  = sq_cat;
                    sq_root_next = {sq_root_reg[SQ_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    // Latch the finished root so both divides see it
                    s_next     = wide_t'(sq_root_next);
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                dv_next   = {mag(num), FRAC_BITS'(0)};
                ud_next   = {1'b0, mag(c_reg)};
                dneg_next = (num < 0) != (c_reg < 0);
                rem_next  = '0;
                q_next    = '0;
                qovf_next = 1'b0;
                cnt_next  = 7'(DIV_BITS);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                dv_next   = {dv_reg[DIV_BITS-2:0], 1'b0};
                qovf_next = qovf_reg || q_reg[WIDE_WIDTH-1];
                if (r65 >= {1'b0, ud_reg})
                begin
                    rem_next = WIDE_WIDTH'(r65 - {1'b0, ud_reg});
                    q_next   = {q_reg[WIDE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = r65[WIDE_WIDTH-1:0];
                    q_next   = {q_reg[WIDE_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                if (!single_reg && !phase_reg)
                begin
                    x1_next    = qsat;
                    phase_next = 1'b1;
                    state_next = S_DLOAD;
                end
                else
                begin
                    x2_next    = qsat;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (valid_reg && tsel > 0 && dclamp > min_dist &&
                    (!found_reg || dclamp < ndist_reg))
                begin
                    found_next = 1'b1;
                    ndist_next = dclamp;
                    ncone_next = item_reg.cone_index;
                    nray_next  = item_reg;
                end
                state_next = item_reg.last_of_ray ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.hit       = found_reg;
                    out_next.distance  = found_reg ? ndist_reg : '0;
                    out_next.hit_cone  = found_reg ? ncone_reg : '0;
                    out_next.hit_pos_x = found_reg ? nray_reg.pos_x : '0;
                    out_next.hit_pos_y = found_reg ? nray_reg.pos_y : '0;
                    out_next.hit_pos_z = found_reg ? nray_reg.pos_z : '0;
                    out_next.hit_dir_x = found_reg ? nray_reg.dir_x : '0;
                    out_next.hit_dir_y = found_reg ? nray_reg.dir_y : '0;
                    out_next.hit_dir_z = found_reg ? nray_reg.dir_z : '0;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        t_reg <= t_next; u_reg <= u_next; s_reg <= s_next;
        x1_reg <= x1_next; x2_reg <= x2_next;
        single_reg <= single_next; valid_reg <= valid_next; phase_reg <= phase_next;
        mx_reg <= mx_next; my_reg <= my_next; mneg_reg <= mneg_next;
        macc_reg <= macc_next; mcnt_reg <= mcnt_next;
        sq_op_reg <= sq_op_next; sq_rem_reg <= sq_rem_next; sq_root_reg <= sq_root_next;
        dv_reg <= dv_next; rem_reg <= rem_next; q_reg <= q_next; ud_reg <= ud_next;
        qovf_reg <= qovf_next; dneg_reg <= dneg_next; cnt_reg <= cnt_next;
        nray_reg <= nray_next;
        out_reg <= out_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            ndist_reg     <= '0;
            ncone_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            ndist_reg     <= ndist_next;
            ncone_reg     <= ncone_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/ray_cone_nearest_hit.sv -----
// Top level of the ray-cone nearest-hit block: input queue, engine and configuration register.
//
// Usage:
//   Input side is a queue: drive item and push; a transaction completes at a
//   rising edge with push high and full low. One item tests one cone for a ray;
//   first_of_ray clears the nearest-hit record, last_of_ray reports it.
//   Result side is a queue: while empty is low, result holds the oldest report;
//   raise pop to take it. Only items with last_of_ray produce a result.
//   Configuration: cfg_valid/cfg_data write min_hit_distance; cfg_ready is
//   always high. Write it only while the block is idle.
//   Sequencing: the engine works on one item at a time. Each item runs fourteen
//   multiplies on a shared 32x32 multiplier; a hit with two roots adds a square
//   root and two divides on the one divider, and a single root adds one divide.
//   The input queue holds QUEUE_DEPTH items so the source can run ahead.
//   Reset empties both queues, clears the record and loads min_hit_distance
//   with 66 (about 0.001). When the receiver stalls, the engine holds a
//   finished report until the output register frees, while the input queue
//   keeps accepting up to its depth.
`default_nettype none
module ray_cone_nearest_hit
    import rcnh_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    logic [31:0]  min_dist_reg;
    queue_stat_t  stat;
    logic         take;

    // Configuration register is always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RESET;
        end
        else if (cfg_valid)
        begin
            min_dist_reg <= cfg_data;
        end
    end

    // Front: hold incoming items
    rcnh_front #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .take  (take),
        .stat  (stat)
    );

    // Back: solve the quadratic, keep the nearest hit, drive the result queue
    rcnh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .take     (take),
        .min_dist (min_dist_reg),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );
endmodule
`default_nettype wire
